FILE: sv/olrb_pkg.sv
// shared types and constants for the octree level range builder
package olrb_pkg;

	// deepest octree supported by default
	localparam int OLRB_MAX_LEVELS = 20;

	// fixed field widths
	localparam int CODE_W   = 61;
	localparam int HEIGHT_W = 21;
	localparam int LEVEL_W  = 5;
	localparam int CFG_W    = 5;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_N_LEVELS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL = 2'd1;

	// per-level run record kept in the level memory
	typedef struct packed {
		logic [CODE_W-1:0] run_start;
		logic [CODE_W-1:0] run_end;
		logic [CODE_W-1:0] cube_count;
	} entry_t;

	// one result item
	typedef struct packed {
		logic [LEVEL_W-1:0]  level;
		logic [CODE_W-1:0]   run_first;
		logic [CODE_W-1:0]   run_final;
		logic [CODE_W-1:0]   cubes;
		logic [HEIGHT_W-1:0] height;
		logic                flush;
		logic                err;
	} res_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH,
		ST_FIN
	} state_t;

endpackage

FILE: sv/octree_level_range_builder_core.sv
// octree level range builder: per-level run tracking over a level memory
//
//  channel | handshake               | payload
//  --------+-------------------------+--------------------------------------------
//  in      | in_valid / in_stall     | leaf_code, end_of_data
//  out     | out_valid / out_stall   | tree_level, run_first, run_final, cube_total,
//          |                         | height_extent, is_flush, order_error, last
//  cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// a leaf code takes one memory read to prime, then one level of the run memory per
// cycle from max_level toward the root while the output has room, then a finish step.
// an end marker sweeps every level of the run memory, starting from the root.
// the level memory (one read, one write per cycle) sets the pace.
// reset clears all control state, the level started bits and the peak height.
// a stalled output holds the walk or the flush sweep whenever a new result has no room to go.
module octree_level_range_builder_core
	import olrb_pkg::*;
#(
	parameter int MAX_LEVELS = OLRB_MAX_LEVELS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [CODE_W-1:0]    leaf_code,
	input  logic                 end_of_data,
	// output channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [LEVEL_W-1:0]   tree_level,
	output logic [CODE_W-1:0]    run_first,
	output logic [CODE_W-1:0]    run_final,
	output logic [CODE_W-1:0]    cube_total,
	output logic [HEIGHT_W-1:0]  height_extent,
	output logic                 is_flush,
	output logic                 order_error,
	output logic                 last,
	// configuration channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int DEPTH = MAX_LEVELS + 1;
	localparam int LVL_W = $clog2(DEPTH);
	localparam logic [LVL_W-1:0]  LVL_TOP = LVL_W'(MAX_LEVELS);
	localparam logic [CFG_W-1:0]  CFG_TOP = CFG_W'(MAX_LEVELS);
	localparam logic [CODE_W-1:0] CNT_MAX = {CODE_W{1'b1}};

	state_t state_q, state_d;

	logic [CFG_W-1:0]    n_levels_q, max_level_q;
	logic [LVL_W-1:0]    cur_lvl_q;
	logic [CODE_W-1:0]   id_q;
	logic [DEPTH-1:0]    started_q;
	logic [HEIGHT_W-1:0] peak_q;

	entry_t level_mem [DEPTH];
	entry_t mem_rd_q;

	res_t hold_q, out_q, emit_res;
	logic hold_valid_q, out_valid_q, out_last_q;

	logic                rd_en, wr_en;
	logic [LVL_W-1:0]    rd_addr, wr_addr;
	entry_t              wr_data;
	logic                emit, adv, walk_stop, push_last, can_emit, in_take;

	logic [LVL_W-1:0]    ml_eff;
	logic [CFG_W-1:0]    ml_wide, n_cap, n_eff, cell_shift;
	logic [HEIGHT_W-1:0] y_bits, h_new;

	logic [CODE_W:0]     end_plus;
	logic                is_next, is_same, is_below;
	logic [CODE_W-1:0]   cnt_inc;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign can_emit  = !out_valid_q || !out_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_levels_q  <= CFG_W'(10);
			max_level_q <= CFG_W'(5);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_N_LEVELS:  n_levels_q  <= cfg_data;
				REG_MAX_LEVEL: max_level_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective levels and cell size shift
	always_comb begin
		ml_eff     = (max_level_q > CFG_TOP) ? LVL_TOP : max_level_q[LVL_W-1:0];
		ml_wide    = CFG_W'(ml_eff);
		n_cap      = (n_levels_q > CFG_TOP) ? CFG_TOP : n_levels_q;
		n_eff      = (n_cap < ml_wide) ? ml_wide : n_cap;
		cell_shift = n_eff - ml_wide;
	end

	// de-interleaved y of the incoming leaf plus one cell
	always_comb begin
		y_bits = '0;
		for (int j = 0; j < MAX_LEVELS; j++) begin
			if (j < int'(ml_eff) && leaf_code != CODE_W'(1))
				y_bits[j] = leaf_code[3*j+1];
		end
		h_new = (y_bits + HEIGHT_W'(1)) << cell_shift;
	end

	// run compare against the stored record
	always_comb begin
		end_plus = {1'b0, mem_rd_q.run_end} + (CODE_W+1)'(1);
		is_next  = (end_plus == {1'b0, id_q});
		is_same  = (mem_rd_q.run_end == id_q);
		is_below = (mem_rd_q.run_end > id_q);
		cnt_inc  = (mem_rd_q.cube_count != CNT_MAX) ? mem_rd_q.cube_count + CODE_W'(1)
		                                            : mem_rd_q.cube_count;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = end_of_data ? ST_FLUSH : ST_WALK;
			end
			ST_WALK: begin
				if (adv && walk_stop)
					state_d = ST_FIN;
			end
			ST_FLUSH: begin
				if (adv && cur_lvl_q == LVL_TOP)
					state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!hold_valid_q || can_emit)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs: memory access, result emission
	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = '0;
		wr_en     = 1'b0;
		wr_addr   = cur_lvl_q;
		wr_data   = '{run_start: id_q, run_end: id_q, cube_count: CODE_W'(1)};
		emit      = 1'b0;
		emit_res  = '0;
		walk_stop = 1'b0;
		push_last = 1'b0;
		adv       = 1'b0;
		emit_res.level = LEVEL_W'(cur_lvl_q);
		case (state_q)
			ST_IDLE: begin
				rd_en   = in_valid;
				rd_addr = end_of_data ? '0 : ml_eff;
			end
			ST_WALK: begin
				if (!started_q[cur_lvl_q]) begin
					wr_en = 1'b1;
				end else if (is_next) begin
					wr_en   = 1'b1;
					wr_data = '{run_start: mem_rd_q.run_start, run_end: id_q,
					            cube_count: cnt_inc};
				end else if (is_same) begin
					walk_stop = 1'b1;
				end else if (is_below) begin
					emit      = 1'b1;
					walk_stop = 1'b1;
					emit_res.run_first = mem_rd_q.run_end;
					emit_res.run_final = id_q;
					emit_res.err       = 1'b1;
				end else begin
					emit    = 1'b1;
					wr_en   = 1'b1;
					wr_data = '{run_start: id_q, run_end: id_q, cube_count: cnt_inc};
					emit_res.run_first = mem_rd_q.run_start;
					emit_res.run_final = mem_rd_q.run_end;
				end
				if (cur_lvl_q == '0)
					walk_stop = 1'b1;
				adv   = !(emit && hold_valid_q && !can_emit);
				wr_en = wr_en && adv;
				if (adv && !walk_stop) begin
					rd_en   = 1'b1;
					rd_addr = cur_lvl_q - LVL_W'(1);
				end
			end
			ST_FLUSH: begin
				emit = started_q[cur_lvl_q];
				emit_res.run_first = mem_rd_q.run_start;
				emit_res.run_final = mem_rd_q.run_end;
				emit_res.cubes     = mem_rd_q.cube_count;
				emit_res.height    = peak_q;
				emit_res.flush     = 1'b1;
				adv = !(emit && hold_valid_q && !can_emit);
				if (adv && cur_lvl_q != LVL_TOP) begin
					rd_en   = 1'b1;
					rd_addr = cur_lvl_q + LVL_W'(1);
				end
			end
			ST_FIN: begin
				push_last = hold_valid_q && can_emit;
			end
			default: ;
		endcase
	end

	// level memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en)
			level_mem[wr_addr] <= wr_data;
		if (rd_en)
			mem_rd_q <= level_mem[rd_addr];
	end

	// sequencer state, level pointer, started bits, peak height
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cur_lvl_q <= '0;
			started_q <= '0;
			peak_q    <= '0;
		end else begin
			state_q <= state_d;
			if (in_take) begin
				cur_lvl_q <= end_of_data ? '0 : ml_eff;
				if (!end_of_data && h_new > peak_q)
					peak_q <= h_new;
			end
			if (state_q == ST_WALK && adv) begin
				if (wr_en)
					started_q[cur_lvl_q] <= 1'b1;
				if (!walk_stop)
					cur_lvl_q <= cur_lvl_q - LVL_W'(1);
			end
			if (state_q == ST_FLUSH && adv) begin
				if (cur_lvl_q == LVL_TOP) begin
					started_q <= '0;
					peak_q    <= '0;
				end else begin
					cur_lvl_q <= cur_lvl_q + LVL_W'(1);
				end
			end
		end
	end

	// node code at the current level
	always_ff @(posedge clk) begin
		if (in_take)
			id_q <= leaf_code;
		else if (state_q == ST_WALK && adv && !walk_stop)
			id_q <= id_q >> 3;
	end

	// one result held back until it is known whether it is the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (emit && adv)
				hold_valid_q <= 1'b1;
			else if (push_last)
				hold_valid_q <= 1'b0;
			if ((emit && adv && hold_valid_q) || push_last)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// result payload registers
	always_ff @(posedge clk) begin
		if (emit && adv)
			hold_q <= emit_res;
		if ((emit && adv && hold_valid_q) || push_last) begin
			out_q      <= hold_q;
			out_last_q <= push_last;
		end
	end

	// output ports
	assign out_valid     = out_valid_q;
	assign tree_level    = out_q.level;
	assign run_first     = out_q.run_first;
	assign run_final     = out_q.run_final;
	assign cube_total    = out_q.cubes;
	assign height_extent = out_q.height;
	assign is_flush      = out_q.flush;
	assign order_error   = out_q.err;
	assign last          = out_last_q;

	// no result may be left behind when a new item can be taken
	a_idle_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !hold_valid_q)
		else $error("held result left in idle");

	// the flush sweep only reads the level memory
	a_flush_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FLUSH |-> !wr_en)
		else $error("level memory written during flush");

	// the end of a flush sweep clears all run state
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && adv && cur_lvl_q == LVL_TOP)
		|=> (started_q == '0 && peak_q == '0))
		else $error("run state not cleared after flush");

	// the level pointer stays inside the memory
	a_lvl_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> cur_lvl_q <= LVL_TOP)
		else $error("level pointer out of range");

	// a flush result never carries an order error
	a_flush_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.flush && out_q.err))
		else $error("order error on flush result");

endmodule
